### sv/gb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and kernel table for the Gaussian blur block.
package gb_pkg;

    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int OUT_COL_W = 10;
    localparam int ROW_W     = 12;
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 13;
    localparam int MAX_ROWS  = 4096;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Position and end-of-frame flag that ride along with a pixel.
    typedef struct packed {
        logic [OUT_COL_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } t_pos;

    // Normalized 1-D Gaussian, Q0.24, radius 1..4, indexed by distance.
    localparam logic [23:0] GAUSS_1D [4][5] = '{
        '{24'd7581000, 24'd4598108, 24'd0,       24'd0,       24'd0},
        '{24'd6754842, 24'd4097019, 24'd914168,  24'd0,       24'd0},
        '{24'd4541294, 24'd3636383, 24'd1866981, 24'd614597,  24'd0},
        '{24'd3425298, 24'd3022815, 24'd2077548, 24'd1112032, 24'd463564}
    };

    // 2-D tap weight in Q0.coef_bits, rounded half up.
    function automatic logic [31:0] gb_weight(int radius, int coef_bits, int di, int dj);
        logic [63:0] p;
        logic [63:0] half;
        p    = 64'(GAUSS_1D[radius-1][di]) * 64'(GAUSS_1D[radius-1][dj]);
        half = 64'(1) << (47 - coef_bits);
        return 32'((p + half) >> (48 - coef_bits));
    endfunction

endpackage

### sv/gb_pix_if.sv
`timescale 1ns / 1ps
// Pixel input channel: valid/ready with one RGBA pixel per transaction.
interface gb_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
    logic       start_of_frame;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha, start_of_frame,
        input  ready
    );
    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue, pixel_alpha, start_of_frame,
        output ready
    );
endinterface

### sv/gb_res_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready with one blurred pixel per transaction.
interface gb_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [9:0]  out_column;
    logic [11:0] out_row;
    logic        last_of_frame;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, out_column, out_row,
               last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, out_column, out_row,
               last_of_frame,
        output ready
    );
endinterface

### sv/gb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, read-first, registered read data.
module gb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### sv/gb_window.sv
`timescale 1ns / 1ps
// Frame counters, line store read-modify-write and the pixel window.
module gb_window #(
    parameter int RADIUS    = 2,
    parameter int MAX_WIDTH = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gb_pkg::t_cfg_wr i_cfg,
    gb_pix_if.sink          i_pix,
    output logic            o_win_valid,
    input  logic            i_win_ready,
    output logic [gb_pkg::PIX_W-1:0] o_win [2*RADIUS+1][2*RADIUS+1],
    output gb_pkg::t_pos    o_pos
);
    localparam int SPAN = 2 * RADIUS;
    localparam int WIN  = SPAN + 1;
    localparam int PW   = gb_pkg::PIX_W;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EWW  = $clog2(MAX_WIDTH + 1);
    localparam int BW   = $clog2(SPAN);
    localparam int LW   = PW * SPAN;
    localparam int RW   = gb_pkg::ROW_W;
    localparam int HW   = gb_pkg::IMG_H_W;

    // configuration
    logic [gb_pkg::IMG_W_W-1:0] r_width;
    logic [HW-1:0]              r_height;

    // frame position of the next pixel
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [BW-1:0] r_bank;

    logic [EWW-1:0] ew;
    logic [HW-1:0]  eh;
    logic [CW-1:0]  col_cur, n_col;
    logic [RW-1:0]  row_cur, n_row;
    logic [BW-1:0]  bank_cur, n_bank;
    logic           emit_cur, last_cur;

    // stage 1: line store read in flight
    logic            r1_valid;
    logic [CW-1:0]   r1_col;
    logic [BW-1:0]   r1_bank;
    logic [PW-1:0]   r1_px;
    logic            r1_emit;
    gb_pkg::t_pos    r1_pos;

    // stage 2: window holds an emitting pixel
    logic            r2_valid;
    gb_pkg::t_pos    r2_pos;
    logic [PW-1:0]   r_win [WIN][WIN];

    logic            r_fwd;
    logic [LW-1:0]   r_fwd_word;

    logic            en1, en2, acc, wr;
    logic [LW-1:0]   ram_q, rd_word, wr_word;
    logic [PW-1:0]   rd_lane [SPAN];
    logic [PW-1:0]   col_in [SPAN];
    logic [PW-1:0]   px_in;

    assign en2 = !r2_valid || i_win_ready;
    assign en1 = !r1_valid || en2;
    assign i_pix.ready = en1;
    assign acc = i_pix.valid && en1;
    assign wr  = r1_valid && en2;
    assign px_in = {i_pix.pixel_alpha, i_pix.pixel_blue, i_pix.pixel_green, i_pix.pixel_red};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= gb_pkg::IMG_W_W'(1024);
            r_height <= HW'(1024);
        end else if (i_cfg.we) begin
            unique case (gb_pkg::t_cfg_idx'(i_cfg.idx))
                gb_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg.data[gb_pkg::IMG_W_W-1:0];
                gb_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg.data[HW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_width == '0) begin
            ew = EWW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            ew = EWW'(MAX_WIDTH);
        end else begin
            ew = EWW'(r_width);
        end
        priority if (r_height == '0) begin
            eh = HW'(1);
        end else if (32'(r_height) > gb_pkg::MAX_ROWS) begin
            eh = HW'(gb_pkg::MAX_ROWS);
        end else begin
            eh = r_height;
        end
    end

    // Place the incoming pixel and work out where the next one goes.
    always_comb begin
        col_cur  = i_pix.start_of_frame ? '0 : r_col;
        row_cur  = i_pix.start_of_frame ? '0 : r_row;
        bank_cur = i_pix.start_of_frame ? '0 : r_bank;
        if (32'(col_cur) >= 32'(ew)) begin
            col_cur = '0;
        end
        if (32'(row_cur) >= 32'(eh)) begin
            row_cur  = '0;
            bank_cur = '0;
        end
        emit_cur = (32'(col_cur) >= SPAN) && (32'(row_cur) >= SPAN);
        last_cur = (32'(col_cur) == 32'(ew) - 1) && (32'(row_cur) == 32'(eh) - 1);
        n_col  = col_cur + CW'(1);
        n_row  = row_cur;
        n_bank = bank_cur;
        if (32'(col_cur) + 1 >= 32'(ew)) begin
            n_col = '0;
            if (32'(row_cur) + 1 >= 32'(eh)) begin
                n_row  = '0;
                n_bank = '0;
            end else begin
                n_row  = row_cur + RW'(1);
                n_bank = (bank_cur == BW'(SPAN - 1)) ? '0 : bank_cur + BW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_bank   <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (acc) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_bank <= n_bank;
                // same column written back while being read: take the new word
                r_fwd  <= wr && (r1_col == col_cur);
            end
            if (en1) begin
                r1_valid <= acc;
            end
            if (en2) begin
                r2_valid <= r1_valid && r1_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_col     <= col_cur;
            r1_bank    <= bank_cur;
            r1_px      <= px_in;
            r1_emit    <= emit_cur;
            r1_pos.col <= gb_pkg::OUT_COL_W'(32'(col_cur) - RADIUS);
            r1_pos.row <= RW'(32'(row_cur) - RADIUS);
            r1_pos.last <= last_cur;
            r_fwd_word <= wr_word;
        end
        if (en2) begin
            r2_pos <= r1_pos;
        end
    end

    // One word per column holds that column of all buffered rows.
    gb_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (r1_col),
        .i_wdata (wr_word),
        .i_re    (acc),
        .i_raddr (col_cur),
        .o_rdata (ram_q)
    );

    assign rd_word = r_fwd ? r_fwd_word : ram_q;

    // lane r1_bank holds the oldest row; it is replaced by the new pixel
    always_comb begin
        for (int b = 0; b < SPAN; b++) begin
            rd_lane[b] = rd_word[b*PW +: PW];
            wr_word[b*PW +: PW] = (BW'(b) == r1_bank) ? r1_px : rd_word[b*PW +: PW];
        end
    end

    for (genvar k = 0; k < SPAN; k++) begin : g_col
        logic [BW:0] sel_raw;
        logic [BW:0] sel;
        assign sel_raw = {1'b0, r1_bank} + (BW+1)'(k);
        assign sel     = (32'(sel_raw) >= SPAN) ? sel_raw - (BW+1)'(SPAN) : sel_raw;
        assign col_in[k] = rd_lane[sel[BW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN; i++) begin
                for (int j = 0; j < WIN; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (en2 && r1_valid) begin
            for (int i = 0; i < WIN; i++) begin
                for (int j = 0; j < WIN - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
            end
            for (int k = 0; k < SPAN; k++) begin
                r_win[k][WIN-1] <= col_in[k];
            end
            r_win[SPAN][WIN-1] <= r1_px;
        end
    end

    assign o_win       = r_win;
    assign o_win_valid = r2_valid;
    assign o_pos       = r2_pos;

    a_bank_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == '0) |-> (r_bank == '0))
        else $error("line bank out of step with row counter");
    a_acc_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r1_valid)
        else $error("accepted pixel lost before line store stage");
    a_win_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en2 && !r1_valid) |=> $stable(r_win[RADIUS][RADIUS]))
        else $error("window shifted without a pixel");
endmodule

### sv/gb_conv.sv
`timescale 1ns / 1ps
// Weighted sum of the window: products, row sums, total, saturated output.
module gb_conv #(
    parameter int RADIUS    = 2,
    parameter int COEF_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_win_valid,
    output logic         o_win_ready,
    input  logic [gb_pkg::PIX_W-1:0] i_win [2*RADIUS+1][2*RADIUS+1],
    input  gb_pkg::t_pos i_pos,
    gb_res_if.source     o_res
);
    localparam int WIN = 2 * RADIUS + 1;
    localparam int NCH = gb_pkg::NUM_CH;
    localparam int CHW = gb_pkg::CH_W;
    localparam int PW  = CHW + COEF_BITS;
    localparam int SW  = PW + 4;
    localparam int TW  = PW + 7;
    localparam int QW  = TW - COEF_BITS;

    logic [PW-1:0] prod  [NCH][WIN][WIN];
    logic [PW-1:0] r_prod [NCH][WIN][WIN];
    logic [SW-1:0] row_sum [NCH][WIN];
    logic [SW-1:0] r_row_sum [NCH][WIN];
    logic [TW-1:0] tot [NCH];
    logic [TW-1:0] r_tot [NCH];
    logic [CHW-1:0] sat [NCH];
    logic [CHW-1:0] r_o_ch [NCH];

    logic r_p_valid, r_s_valid, r_t_valid, r_o_valid;
    logic [CHW-1:0] r_p_alpha, r_s_alpha, r_t_alpha, r_o_alpha;
    gb_pkg::t_pos r_p_pos, r_s_pos, r_t_pos, r_o_pos;
    logic en_p, en_s, en_t, en_o;

    assign en_o = !r_o_valid || o_res.ready;
    assign en_t = !r_t_valid || en_o;
    assign en_s = !r_s_valid || en_t;
    assign en_p = !r_p_valid || en_s;
    assign o_win_ready = en_p;

    // constant weight per tap, folded into the multiplier
    for (genvar i = 0; i < WIN; i++) begin : g_row
        for (genvar j = 0; j < WIN; j++) begin : g_tap
            localparam int DI = (i < RADIUS) ? RADIUS - i : i - RADIUS;
            localparam int DJ = (j < RADIUS) ? RADIUS - j : j - RADIUS;
            localparam logic [COEF_BITS-1:0] WT =
                COEF_BITS'(gb_pkg::gb_weight(RADIUS, COEF_BITS, DI, DJ));
            for (genvar c = 0; c < NCH; c++) begin : g_ch
                assign prod[c][i][j] = PW'(i_win[i][j][c*CHW +: CHW]) * PW'(WT);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            tot[c] = '0;
            for (int i = 0; i < WIN; i++) begin
                row_sum[c][i] = '0;
                for (int j = 0; j < WIN; j++) begin
                    row_sum[c][i] = row_sum[c][i] + SW'(r_prod[c][i][j]);
                end
                tot[c] = tot[c] + TW'(r_row_sum[c][i]);
            end
            // rounded weights can sum past one
            sat[c] = (r_tot[c][TW-1:COEF_BITS] > QW'(255)) ? CHW'(255)
                                                           : r_tot[c][COEF_BITS +: CHW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_t_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_p) r_p_valid <= i_win_valid;
            if (en_s) r_s_valid <= r_p_valid;
            if (en_t) r_t_valid <= r_s_valid;
            if (en_o) r_o_valid <= r_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p) begin
            r_prod    <= prod;
            r_p_alpha <= i_win[RADIUS][RADIUS][3*CHW +: CHW];
            r_p_pos   <= i_pos;
        end
        if (en_s) begin
            r_row_sum <= row_sum;
            r_s_alpha <= r_p_alpha;
            r_s_pos   <= r_p_pos;
        end
        if (en_t) begin
            r_tot     <= tot;
            r_t_alpha <= r_s_alpha;
            r_t_pos   <= r_s_pos;
        end
        if (en_o) begin
            r_o_ch    <= sat;
            r_o_alpha <= r_t_alpha;
            r_o_pos   <= r_t_pos;
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.out_red       = r_o_ch[0];
    assign o_res.out_green     = r_o_ch[1];
    assign o_res.out_blue      = r_o_ch[2];
    assign o_res.out_alpha     = r_o_alpha;
    assign o_res.out_column    = r_o_pos.col;
    assign o_res.out_row       = r_o_pos.row;
    assign o_res.last_of_frame = r_o_pos.last;

    a_prod_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !en_s) |=> (r_p_valid && $stable(r_p_alpha)))
        else $error("product stage dropped a stalled pixel");
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && o_res.ready && !r_t_valid) |=> !r_o_valid)
        else $error("output repeated after transaction");
endmodule

### sv/gaussian_blur_rgba.sv
`timescale 1ns / 1ps
// Top level of the streaming RGBA Gaussian blur.
//
//   channel   dir  handshake          payload
//   i_pix     in   valid/ready        pixel_red/green/blue/alpha, start_of_frame
//   o_res     out  valid/ready        out_red/green/blue/alpha, out_column, out_row,
//                                     last_of_frame
//   i_cfg_*   in   write enable only  index 0 image_width, 1 image_height
//
// One pixel per clock sustained while o_res is ready; o_res.valid rises once the pixel's
// transaction has passed line store read, window, products, row sums, total and output.
// The line store is one RAM word per column (2*RADIUS pixels wide); each pixel
// reads its column and writes it back as it leaves the line store read stage, with
// forwarding when the same column is read again at once (frames one pixel wide).
// Synchronous reset; the line store is not cleared. i_pix.ready drops only when
// every pipeline stage is full behind a stalled output.
module gaussian_blur_rgba #(
    parameter int RADIUS    = 2,
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    gb_pix_if.sink                          i_pix,
    gb_res_if.source                        o_res
);
    localparam int WIN = 2 * RADIUS + 1;

    gb_pkg::t_cfg_wr cfg;
    gb_pkg::t_pos    win_pos;
    logic            win_valid;
    logic            win_ready;
    logic [gb_pkg::PIX_W-1:0] win [WIN][WIN];

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    gb_window #(
        .RADIUS    (RADIUS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pix       (i_pix),
        .o_win_valid (win_valid),
        .i_win_ready (win_ready),
        .o_win       (win),
        .o_pos       (win_pos)
    );

    gb_conv #(
        .RADIUS    (RADIUS),
        .COEF_BITS (COEF_BITS)
    ) u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_valid (win_valid),
        .o_win_ready (win_ready),
        .i_win       (win),
        .i_pos       (win_pos),
        .o_res       (o_res)
    );
endmodule

### bench/gaussian_blur_rgba_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_blur_rgba: random RGBA frames against a predictor.
module gaussian_blur_rgba_tb;

    localparam int RADIUS       = 2;
    localparam int SPAN         = 2 * RADIUS;
    localparam int WIN          = 2 * RADIUS + 1;
    localparam int MAX_W        = 1024;
    localparam int MAX_H        = gb_pkg::MAX_ROWS;
    localparam int COEF_BITS    = 16;
    localparam int DRAIN_CYCLES = 12;
    localparam int STUCK_LIMIT  = 5000;

    // 1-D normalized Gaussian for radius 2 in Q0.24, indexed by distance from center
    localparam longint unsigned GAUSS_Q24 [0:RADIUS] = '{64'd6754842, 64'd4097019, 64'd914168};

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       sof;
    } pixel_t;

    typedef struct packed {
        logic [7:0]                   red;
        logic [7:0]                   green;
        logic [7:0]                   blue;
        logic [7:0]                   alpha;
        logic [gb_pkg::OUT_COL_W-1:0] column;
        logic [gb_pkg::ROW_W-1:0]     row;
        logic                         last;
    } blur_px_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [gb_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [gb_pkg::CFG_DATA_W-1:0] i_cfg_data;

    gb_pix_if pix_if ();
    gb_res_if res_if ();

    gaussian_blur_rgba #(
        .RADIUS    (RADIUS),
        .MAX_WIDTH (MAX_W),
        .COEF_BITS (COEF_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    bit [31:0]        line_mem [SPAN][MAX_W];
    bit [31:0]        win [WIN][WIN];
    int unsigned      col_cnt = 0;
    int unsigned      row_cnt = 0;
    logic [gb_pkg::IMG_W_W-1:0] reg_width = gb_pkg::IMG_W_W'(1024);
    logic [gb_pkg::IMG_H_W-1:0] reg_height = gb_pkg::IMG_H_W'(1024);

    blur_px_t pending_blur [$];
    int       error_count = 0;
    int       src_idle_pct = 0;
    int       sink_stall_pct = 0;

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic longint unsigned kernel_tap(input int i, input int j);
        int di;
        int dj;
        di = (i < RADIUS) ? RADIUS - i : i - RADIUS;
        dj = (j < RADIUS) ? RADIUS - j : j - RADIUS;
        return (GAUSS_Q24[di] * GAUSS_Q24[dj] + (64'd1 << (47 - COEF_BITS)))
               >> (48 - COEF_BITS);
    endfunction

    // Advances the predictor by one pixel; returns 1 when an interior pixel comes out.
    function automatic bit predict_blur(input pixel_t px, output blur_px_t res);
        bit [31:0]       word;
        int unsigned     ew;
        int unsigned     eh;
        int unsigned     c;
        int unsigned     r;
        longint unsigned sum;
        logic [7:0]      chan [3];
        bit              hit;
        word = {px.alpha, px.blue, px.green, px.red};
        ew = (reg_width == 0) ? 1 : reg_width;
        eh = (reg_height == 0) ? 1 : reg_height;
        if (ew > MAX_W)
            ew = MAX_W;
        if (eh > MAX_H)
            eh = MAX_H;
        if (px.sof) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= ew)
            col_cnt = 0;
        if (row_cnt >= eh)
            row_cnt = 0;
        c = col_cnt;
        r = row_cnt;

        for (int i = 0; i < WIN; i++)
            for (int j = 0; j < WIN - 1; j++)
                win[i][j] = win[i][j + 1];
        for (int k = 0; k < SPAN; k++)
            win[k][WIN - 1] = line_mem[(r + k) % SPAN][c];
        win[SPAN][WIN - 1] = word;
        line_mem[r % SPAN][c] = word;

        res = '0;
        hit = (c >= SPAN && r >= SPAN);
        if (hit) begin
            for (int ch = 0; ch < 3; ch++) begin
                sum = 0;
                for (int i = 0; i < WIN; i++)
                    for (int j = 0; j < WIN; j++)
                        sum += 64'(win[i][j][8*ch +: 8]) * kernel_tap(i, j);
                sum = sum >> COEF_BITS;
                // taps can sum a little above one
                chan[ch] = (sum > 255) ? 8'hFF : sum[7:0];
            end
            res.red    = chan[0];
            res.green  = chan[1];
            res.blue   = chan[2];
            res.alpha  = win[RADIUS][RADIUS][31:24];
            res.column = gb_pkg::OUT_COL_W'(c - RADIUS);
            res.row    = gb_pkg::ROW_W'(r - RADIUS);
            res.last   = (c == ew - 1 && r == eh - 1);
        end

        if (c + 1 >= ew) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= eh) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
        return hit;
    endfunction

    function automatic pixel_t random_pixel(input bit sof);
        pixel_t p;
        {p.red, p.green, p.blue, p.alpha} = $urandom;
        p.sof = sof;
        return p;
    endfunction

    task automatic send_pixel(input pixel_t px);
        blur_px_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid          <= 1'b1;
        pix_if.pixel_red      <= px.red;
        pix_if.pixel_green    <= px.green;
        pix_if.pixel_blue     <= px.blue;
        pix_if.pixel_alpha    <= px.alpha;
        pix_if.start_of_frame <= px.sof;
        // inputs are stable between edges, so ready seen at the falling edge decides the transaction
        @(negedge i_clk);
        while (pix_if.ready !== 1'b1)
            @(negedge i_clk);
        @(posedge i_clk);
        if (predict_blur(px, res))
            pending_blur.push_back(res);
    endtask

    // Opening pixel gets a start mark whenever the counters are off the origin, so a
    // window never reaches line store entries that this frame has not filled.
    task automatic send_frame(input int count, input bit opens_frame);
        bit sof;
        for (int k = 0; k < count; k++) begin
            sof = 1'b0;
            if (k == 0 && opens_frame)
                sof = (col_cnt != 0 || row_cnt != 0) || ($urandom_range(1) == 1);
            send_pixel(random_pixel(sof));
        end
    endtask

    task automatic wait_drain();
        int stuck;
        int seen;
        pix_if.valid <= 1'b0;
        stuck = 0;
        while (pending_blur.size() != 0 && stuck < STUCK_LIMIT) begin
            seen = pending_blur.size();
            @(posedge i_clk);
            stuck = (pending_blur.size() == seen) ? stuck + 1 : 0;
        end
        if (pending_blur.size() != 0) begin
            flag_error($sformatf("%0d expected pixels never came out", pending_blur.size()));
            pending_blur.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input gb_pkg::t_cfg_idx idx, input int value);
        wait_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= gb_pkg::CFG_DATA_W'(value);
        if (idx == gb_pkg::CFG_IMAGE_WIDTH)
            reg_width = gb_pkg::IMG_W_W'(value);
        else
            reg_height = gb_pkg::IMG_H_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    task automatic check_field(input string name, input logic [11:0] got,
                               input logic [11:0] want, input blur_px_t want_px);
        if (got !== want)
            flag_error($sformatf("%s got %0d expected %0d (column %0d row %0d)",
                                 name, got, want, want_px.column, want_px.row));
    endtask

    always @(posedge i_clk)
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(negedge i_clk) begin : result_check
        blur_px_t seen;
        blur_px_t want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            seen = {res_if.out_red, res_if.out_green, res_if.out_blue, res_if.out_alpha,
                    res_if.out_column, res_if.out_row, res_if.last_of_frame};
            if (pending_blur.size() == 0) begin
                flag_error($sformatf("unexpected pixel at column %0d row %0d",
                                     seen.column, seen.row));
            end else begin
                want = pending_blur.pop_front();
                check_field("red", 12'(seen.red), 12'(want.red), want);
                check_field("green", 12'(seen.green), 12'(want.green), want);
                check_field("blue", 12'(seen.blue), 12'(want.blue), want);
                check_field("alpha", 12'(seen.alpha), 12'(want.alpha), want);
                check_field("column", 12'(seen.column), 12'(want.column), want);
                check_field("row", seen.row, want.row, want);
                check_field("last_of_frame", 12'(seen.last), 12'(want.last), want);
            end
        end
    end

    // Single 5x5 frame: one output, saturated red, alternating green.
    task automatic test_saturation_frame();
        pixel_t p;
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 5);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 5);
        for (int k = 0; k < 25; k++) begin
            p.red   = 8'hFF;
            p.green = k[0] ? 8'hFF : 8'h00;
            p.blue  = 8'(k * 10);
            p.alpha = 8'(255 - k);
            p.sof   = (k == 0);
            send_pixel(p);
        end
    endtask

    // Frames of span rows or columns or fewer emit nothing.
    task automatic test_narrow_frames();
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 4);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 9);
        send_frame(36, 1);
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 9);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 4);
        send_frame(36, 1);
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 0);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 0);
        send_frame(5, 1);
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 1);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 6);
        send_frame(6, 1);
    endtask

    // Counters wrap at end of frame; later frames carry no start mark.
    task automatic test_back_to_back_frames();
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 7);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 6);
        send_frame(42, 1);
        send_frame(42, 0);
        send_frame(42, 0);
    endtask

    task automatic test_start_mark_restart();
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 9);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 7);
        send_frame(40, 1);
        send_frame(63, 1);
    endtask

    // Registers lowered mid-frame push the counters out of range.
    task automatic test_shrink_mid_frame();
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 12);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 10);
        send_frame(6 * 12 + 9, 1);
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 6);
        send_frame(18, 0);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 5);
        send_frame(36, 0);
    endtask

    // Upper data bits of the width are dropped; a width above the limit clamps to MAX_W.
    task automatic test_max_width();
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 13'h0805);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 5);
        send_frame(25, 1);
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 13'h1FFF);
        send_frame(30, 1);
    endtask

    // Height above the limit clamps; the partial frame still blurs normally.
    task automatic test_max_height();
        set_reg(gb_pkg::CFG_IMAGE_WIDTH, 5);
        set_reg(gb_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
        send_frame(5 * 10, 1);
    endtask

    task automatic test_random_frames(input int target);
        int  sent;
        int  w;
        int  h;
        int  n;
        int  frame_len;
        int  sel;
        bit  first;
        sent  = 0;
        first = 1'b1;
        w     = 0;
        h     = 0;
        while (sent < target) begin
            if (first || $urandom_range(3) == 0) begin
                sel = $urandom_range(9);
                w = (sel < 7) ? $urandom_range(16, 5) :
                    (sel < 9) ? $urandom_range(4, 0) : $urandom_range(40, 17);
                h = ($urandom_range(4) == 0) ? $urandom_range(4, 0) : $urandom_range(9, 5);
                set_reg(gb_pkg::CFG_IMAGE_WIDTH, w);
                set_reg(gb_pkg::CFG_IMAGE_HEIGHT, h);
                first = 1'b0;
            end
            frame_len = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            sel = $urandom_range(9);
            if (sel == 0) begin
                // cut short; the next frame opens with a start mark
                n = $urandom_range(frame_len, 1);
                send_frame(n, 1);
                sent += n;
            end else if (sel == 1) begin
                // hold off mid-frame until every blurred pixel is out
                n = $urandom_range(frame_len, 1);
                send_frame(n, 1);
                wait_drain();
                send_frame(frame_len - n, 0);
                sent += frame_len;
            end else begin
                send_frame(frame_len, 1);
                sent += frame_len;
            end
        end
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= gb_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data            <= '0;
        pix_if.valid          <= 1'b0;
        pix_if.pixel_red      <= '0;
        pix_if.pixel_green    <= '0;
        pix_if.pixel_blue     <= '0;
        pix_if.pixel_alpha    <= '0;
        pix_if.start_of_frame <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0, 0);
        test_saturation_frame();
        test_narrow_frames();
        set_idling(32, 32);
        test_back_to_back_frames();
        test_start_mark_restart();
        test_shrink_mid_frame();
        set_idling(0, 0);
        test_max_width();
        test_max_height();

        set_idling(0, 0);
        test_random_frames(260);
        set_idling(59, 0);
        test_random_frames(260);
        set_idling(0, 59);
        test_random_frames(260);
        set_idling(32, 32);
        test_random_frames(260);

        wait_drain();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

endmodule
